FILE: hw/rtl/brightness_spiral_walker_top_defines.svh
// Assertion macros for the spiral walker checker.
`ifndef BRIGHTNESS_SPIRAL_WALKER_TOP_DEFINES_SVH
`define BRIGHTNESS_SPIRAL_WALKER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BSW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spiral walker check failed");

// Next-cycle implication, disabled during reset.
`define BSW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spiral walker check failed");

`endif

FILE: hw/rtl/bsw_pkg.sv
// Package: types, constants and tables of the spiral walker.
`timescale 1ns / 1ps
package bsw_pkg;

  localparam int IMAGE_DIM    = 256;
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  localparam int ITER_W       = $clog2(CORDIC_ITERS);
  localparam int STORE_DEPTH  = IMAGE_DIM * IMAGE_DIM;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int DIM_LIM      = (IMAGE_DIM < 256) ? IMAGE_DIM : 256;

  localparam int XY_W = 34;
  localparam int Z_W  = 26;

  localparam logic signed [XY_W-1:0] GAIN_Q30 = XY_W'(652032875);
  localparam logic [15:0] PHASE_STEP   = 16'd1043;
  localparam logic [20:0] RADIUS_LIMIT = 21'd2097151;
  localparam logic [20:0] RECIP_2550   = 21'd1684301;  // ceil(2^32 / 2550)
  localparam logic [10:0] ROUND_2550   = 11'd1275;
  localparam logic [12:0] GROW_BASE    = 13'd255;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_RESTART = 2'd1,
    OP_STEP    = 2'd2
  } op_e;

  localparam logic [1:0] CFG_WIDTH   = 2'd0;
  localparam logic [1:0] CFG_HEIGHT  = 2'd1;
  localparam logic [1:0] CFG_MAXRAD  = 2'd2;
  localparam logic [1:0] CFG_DENSITY = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROT,
    ST_MUL,
    ST_PLACE,
    ST_PIX,
    ST_DIV,
    ST_STEP
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } cordic_status_t;

  function automatic logic signed [Z_W-1:0] atan_lut(input logic [4:0] idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      5'd0:  v = Z_W'(2097152);
      5'd1:  v = Z_W'(1238021);
      5'd2:  v = Z_W'(654136);
      5'd3:  v = Z_W'(332050);
      5'd4:  v = Z_W'(166669);
      5'd5:  v = Z_W'(83416);
      5'd6:  v = Z_W'(41718);
      5'd7:  v = Z_W'(20860);
      5'd8:  v = Z_W'(10430);
      5'd9:  v = Z_W'(5215);
      5'd10: v = Z_W'(2608);
      5'd11: v = Z_W'(1304);
      5'd12: v = Z_W'(652);
      5'd13: v = Z_W'(326);
      5'd14: v = Z_W'(163);
      5'd15: v = Z_W'(81);
      5'd16: v = Z_W'(41);
      5'd17: v = Z_W'(20);
      5'd18: v = Z_W'(10);
      5'd19: v = Z_W'(5);
      5'd20: v = Z_W'(3);
      5'd21: v = Z_W'(1);
      5'd22: v = Z_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: hw/rtl/bsw_intf.sv
// Interfaces: command, result and configuration channels.
`timescale 1ns / 1ps
interface bsw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] pixel_row;
  logic [7:0] pixel_col;
  logic [7:0] pixel_value;
  modport source (output valid, operation, pixel_row, pixel_col, pixel_value, input ready);
  modport sink   (input valid, operation, pixel_row, pixel_col, pixel_value, output ready);
endinterface

interface bsw_out_if;
  logic        valid;
  logic        ready;
  logic        point_valid;
  logic [15:0] point_x;
  logic [15:0] point_y;
  logic        walk_done;
  modport source (output valid, point_valid, point_x, point_y, walk_done, input ready);
  modport sink   (input valid, point_valid, point_x, point_y, walk_done, output ready);
endinterface

interface bsw_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [12:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/bsw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bsw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

FILE: hw/rtl/bsw_cordic.sv
// Iterative CORDIC: cos and sin of a 16-bit phase to Q1.15.
`timescale 1ns / 1ps
module bsw_cordic
  import bsw_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [15:0]         phase_i,
  output cordic_status_t      status_o,
  output logic signed [15:0]  cos_o,
  output logic signed [15:0]  sin_o
);
  logic                   run_q, run_d, fin_q, fin_d;
  logic [ITER_W-1:0]      iter_q, iter_d;
  logic                   flip_q, flip_d;
  logic signed [XY_W-1:0] x_q, x_d, y_q, y_d;
  logic signed [Z_W-1:0]  z_q, z_d;
  logic signed [15:0]     cos_q, cos_d, sin_q, sin_d;
  logic signed [16:0]     ang;
  logic signed [XY_W-1:0] xs, ys, xf, yf;

  function automatic logic signed [15:0] to_q15(input logic signed [XY_W-1:0] v);
    logic signed [XY_W-1:0] t;
    logic signed [XY_W-16:0] r;
    t = v + XY_W'(16384);
    r = t[XY_W-1:15];
    if (r > $signed((XY_W-15)'(32767))) return 16'sd32767;
    if (r < -$signed((XY_W-15)'(32768))) return -16'sd32768;
    return r[15:0];
  endfunction

  always_comb begin
    run_d  = run_q;
    fin_d  = 1'b0;
    iter_d = iter_q;
    flip_d = flip_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    cos_d  = cos_q;
    sin_d  = sin_q;
    ang    = 17'($signed(phase_i));
    xs     = x_q >>> iter_q;
    ys     = y_q >>> iter_q;
    xf     = flip_q ? -x_q : x_q;
    yf     = flip_q ? -y_q : y_q;
    if (start_i) begin
      // fold into [-1/4, 1/4) turn
      flip_d = 1'b0;
      if (ang >= 17'sd16384) begin
        ang    = ang - 17'sd32768;
        flip_d = 1'b1;
      end else if (ang < -17'sd16384) begin
        ang    = ang + 17'sd32768;
        flip_d = 1'b1;
      end
      z_d    = {{(Z_W-25){ang[16]}}, ang, 8'b0};
      x_d    = GAIN_Q30;
      y_d    = '0;
      iter_d = '0;
      run_d  = 1'b1;
    end else if (run_q) begin
      if (!z_q[Z_W-1]) begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - atan_lut(5'(iter_q));
      end else begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + atan_lut(5'(iter_q));
      end
      if (iter_q == ITER_W'(CORDIC_ITERS - 1)) begin
        run_d = 1'b0;
        fin_d = 1'b1;
      end else begin
        iter_d = iter_q + 1'b1;
      end
    end else if (fin_q) begin
      cos_d = to_q15(xf);
      sin_d = to_q15(yf);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      fin_q <= 1'b0;
    end else begin
      run_q <= run_d;
      fin_q <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    iter_q <= iter_d;
    flip_q <= flip_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    cos_q  <= cos_d;
    sin_q  <= sin_d;
  end

  assign status_o.busy = run_q | fin_q;
  assign status_o.done = fin_q;
  assign cos_o = cos_q;
  assign sin_o = sin_q;
endmodule

FILE: hw/rtl/brightness_spiral_walker_top.sv
// Top level of the brightness spiral walker.
//
//   channel | dir | modport | beat carries
//   --------+-----+---------+------------------------------------------------
//   in_i    | in  | sink    | operation, pixel_row, pixel_col, pixel_value
//   out_o   | out | source  | point_valid, point_x, point_y, walk_done
//   cfg_i   | in  | sink    | index, data (always ready)
//
// Pixel write, restart and unused codes produce no result. A step beat that finds
// the walk finished shows its result the next cycle. Any other step runs, from
// accept to result: start, 16 CORDIC iterations, rounding, multiply, placement
// and radius update, which waits for a free result slot; inside the image it
// adds the pixel memory read and the divide-by-reciprocal step.
// Reset is asynchronous, active low; the pixel memory is not cleared.
// A stalled result holds; a new beat is taken once the result slot frees.
`timescale 1ns / 1ps
module brightness_spiral_walker_top
  import bsw_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  bsw_in_if.sink    in_i,
  bsw_out_if.source out_o,
  bsw_cfg_if.sink   cfg_i
);
  // configuration registers
  logic [8:0]  width_q, height_q;
  logic [12:0] maxrad_q;
  logic [10:0] density_q;

  // walk state
  state_e      state_q, state_d;
  logic [20:0] radius_q, radius_d;
  logic [15:0] phase_q, phase_d;

  // datapath registers
  logic signed [37:0] prod_x_q, prod_x_d, prod_y_q, prod_y_d;
  logic [15:0] px_q, px_d, py_q, py_d;
  logic        inside_q, inside_d;
  logic [23:0] num_q, num_d;
  logic [12:0] dr_q, dr_d;

  // result slot
  logic        out_valid_q, out_valid_d;
  logic        pv_q, pv_d, done_q, done_d;
  logic [15:0] ox_q, ox_d, oy_q, oy_d;

  logic        slot_free, in_fire, start;
  logic [8:0]  w_use, h_use;
  logic signed [23:0] px_full, py_full;
  logic [ADDR_W-1:0] raddr, waddr;
  logic        we;
  logic [7:0]  pix;
  logic [44:0] quot_full;
  logic [21:0] sum;
  logic signed [15:0] cos_v, sin_v;
  cordic_status_t cst;

  function automatic logic [8:0] usable_dim(input logic [8:0] v);
    if (v == 9'd0) return 9'd1;
    if (v > 9'(DIM_LIM)) return 9'(DIM_LIM);
    return v;
  endfunction

  assign slot_free   = !out_valid_q || out_o.ready;
  assign in_i.ready  = (state_q == ST_IDLE) && slot_free;
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign w_use = usable_dim(width_q);
  assign h_use = usable_dim(height_q);

  // point placement from the registered products, floor-shifted and sign-extended
  assign px_full = $signed({8'b0, w_use, 7'b0}) + $signed({prod_x_q[37], prod_x_q[37:15]});
  assign py_full = $signed({8'b0, h_use, 7'b0}) + $signed({prod_y_q[37], prod_y_q[37:15]});
  assign raddr   = ADDR_W'(ADDR_W'(py_full[15:8]) * ADDR_W'(IMAGE_DIM)
                   + ADDR_W'(px_full[15:8]));

  // pixel write; drop writes outside the store
  assign we    = in_fire && (in_i.operation == OP_WRITE)
                 && (32'(in_i.pixel_row) < 32'(IMAGE_DIM))
                 && (32'(in_i.pixel_col) < 32'(IMAGE_DIM));
  assign waddr = ADDR_W'(ADDR_W'(in_i.pixel_row) * ADDR_W'(IMAGE_DIM)
                 + ADDR_W'(in_i.pixel_col));

  bsw_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_image (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (in_i.pixel_value),
    .raddr_i (raddr),
    .rdata_o (pix)
  );

  bsw_cordic u_cordic (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .phase_i  (phase_q),
    .status_o (cst),
    .cos_o    (cos_v),
    .sin_o    (sin_v)
  );

  assign quot_full = 45'(num_q) * 45'(RECIP_2550);
  assign sum       = 22'(radius_q) + 22'(dr_q);

  always_comb begin
    state_d     = state_q;
    radius_d    = radius_q;
    phase_d     = phase_q;
    prod_x_d    = prod_x_q;
    prod_y_d    = prod_y_q;
    px_d        = px_q;
    py_d        = py_q;
    inside_d    = inside_q;
    num_d       = num_q;
    dr_d        = dr_q;
    out_valid_d = out_valid_q && !out_o.ready;
    pv_d        = pv_q;
    done_d      = done_q;
    ox_d        = ox_q;
    oy_d        = oy_q;
    start       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_i.operation)
            OP_RESTART: begin
              radius_d = '0;
              phase_d  = '0;
            end
            OP_STEP: begin
              if (radius_q >= {maxrad_q, 8'b0}) begin
                // walk finished: answer at once, change nothing
                out_valid_d = 1'b1;
                pv_d        = 1'b0;
                done_d      = 1'b1;
                ox_d        = '0;
                oy_d        = '0;
              end else begin
                start   = 1'b1;
                state_d = ST_ROT;
              end
            end
            default: ;
          endcase
        end
      end
      ST_ROT: begin
        if (cst.done) state_d = ST_MUL;
      end
      ST_MUL: begin
        prod_x_d = 38'(cos_v) * $signed({17'b0, radius_q});
        prod_y_d = 38'(sin_v) * $signed({17'b0, radius_q});
        state_d  = ST_PLACE;
      end
      ST_PLACE: begin
        px_d     = px_full[15:0];
        py_d     = py_full[15:0];
        inside_d = !px_full[23] && (px_full[22:0] < 23'({w_use, 8'b0}))
                   && !py_full[23] && (py_full[22:0] < 23'({h_use, 8'b0}));
        if (inside_d) begin
          state_d = ST_PIX;
        end else begin
          dr_d    = 13'(density_q);
          state_d = ST_STEP;
        end
      end
      ST_PIX: begin
        num_d   = 24'(density_q) * 24'(GROW_BASE + 13'(pix) * 13'd20) + 24'(ROUND_2550);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        dr_d    = quot_full[44:32];
        state_d = ST_STEP;
      end
      ST_STEP: begin
        // hold until the result slot frees
        if (slot_free) begin
          radius_d    = (sum > 22'(RADIUS_LIMIT)) ? RADIUS_LIMIT : sum[20:0];
          phase_d     = phase_q + PHASE_STEP;
          out_valid_d = 1'b1;
          pv_d        = inside_q;
          done_d      = 1'b0;
          ox_d        = inside_q ? px_q : 16'd0;
          oy_d        = inside_q ? py_q : 16'd0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      radius_q    <= '0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
      width_q     <= 9'd256;
      height_q    <= 9'd256;
      maxrad_q    <= 13'd500;
      density_q   <= 11'd256;
    end else begin
      state_q     <= state_d;
      radius_q    <= radius_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_WIDTH:   width_q   <= cfg_i.data[8:0];
          CFG_HEIGHT:  height_q  <= cfg_i.data[8:0];
          CFG_MAXRAD:  maxrad_q  <= cfg_i.data;
          CFG_DENSITY: density_q <= cfg_i.data[10:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_x_q <= prod_x_d;
    prod_y_q <= prod_y_d;
    px_q     <= px_d;
    py_q     <= py_d;
    inside_q <= inside_d;
    num_q    <= num_d;
    dr_q     <= dr_d;
    pv_q     <= pv_d;
    done_q   <= done_d;
    ox_q     <= ox_d;
    oy_q     <= oy_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.point_valid = pv_q;
  assign out_o.point_x     = ox_q;
  assign out_o.point_y     = oy_q;
  assign out_o.walk_done   = done_q;
endmodule

FILE: hw/rtl/bsw_checker.sv
// Port-level checker for the spiral walker, bound to the top level.
`timescale 1ns / 1ps
`include "brightness_spiral_walker_top_defines.svh"
module bsw_checker
  import bsw_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic [1:0]  in_op_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        point_valid_i,
  input logic [15:0] point_x_i,
  input logic [15:0] point_y_i,
  input logic        walk_done_i
);
  logic stall, non_step;
  assign stall    = out_valid_i && !out_ready_i;
  assign non_step = in_valid_i && in_ready_i && (in_op_i != OP_STEP);

  `BSW_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, stall, out_valid_i)
  `BSW_ASSERT_NOW(a_point_or_done, clk_i, rst_ni, out_valid_i, !(point_valid_i && walk_done_i))
  `BSW_ASSERT_NOW(a_zero_off_image, clk_i, rst_ni, out_valid_i && !point_valid_i, (point_x_i == 16'd0) && (point_y_i == 16'd0))
  `BSW_ASSERT_NEXT(a_no_result_from_other_ops, clk_i, rst_ni, non_step, out_valid_i == $past(stall))
endmodule

bind brightness_spiral_walker_top bsw_checker u_bsw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_op_i       (in_i.operation),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .point_valid_i (out_o.point_valid),
  .point_x_i     (out_o.point_x),
  .point_y_i     (out_o.point_y),
  .walk_done_i   (out_o.walk_done)
);

FILE: test/tb_brightness_spiral_walker_top.sv
// Testbench for the brightness spiral walker: directed table, then random walks.
`timescale 1ns / 1ps
module tb_brightness_spiral_walker_top;
  import bsw_pkg::*;

  // Operation code the block ignores.
  localparam logic [1:0] OP_SPARE = 2'd3;

  // Result of one step as the block reports it.
  typedef struct packed {
    logic        pv;
    logic [15:0] x;
    logic [15:0] y;
    logic        done;
  } point_t;

  // One row of the directed table. chk set means the typed-in result is used.
  typedef struct {
    logic [1:0] op;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] val;
    bit         chk;
    point_t     res;
  } row_t;

  logic clk_i;
  logic rst_ni;

  bsw_in_if  in_if ();
  bsw_out_if out_if ();
  bsw_cfg_if cfg_if ();

  brightness_spiral_walker_top uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // Predictor state: image, written marks, walk position and register copies.
  logic [7:0]  img_mem [STORE_DEPTH];
  bit          img_set [STORE_DEPTH];
  logic [20:0] walk_radius;
  logic [15:0] walk_phase;
  logic [8:0]  reg_width;
  logic [8:0]  reg_height;
  logic [12:0] reg_maxrad;
  logic [10:0] reg_density;

  point_t expected_points[$];
  point_t typed_points[$];  // typed-in results from the table, checked as well
  bit     typed_flags[$];

  int  err_count;
  int  cycle_count;
  int  sent_count;
  bit  idle_enable;
  bit  hold_off;

  // Floor shift of a signed 64-bit value.
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_q15(longint v);
    longint r;
    r = floor_shift(v + 16384, 15);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  function automatic void rotate_phase(input logic [15:0] ph, output longint c,
                                       output longint s);
    longint a, x, y, z, xs, ys;
    longint tab [24];
    bit flip;
    tab = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
            10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};
    a = ph;
    flip = 0;
    if (a >= 32768) a -= 65536;
    if (a >= 16384) begin
      a -= 32768;
      flip = 1;
    end else if (a < -16384) begin
      a += 32768;
      flip = 1;
    end
    z = a * 256;
    x = 652032875;
    y = 0;
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      xs = floor_shift(x, i);
      ys = floor_shift(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= tab[i];
      end else begin
        x += ys; y -= xs; z += tab[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = round_q15(x);
    s = round_q15(y);
  endfunction

  function automatic longint fit_dim(logic [8:0] v);
    if (v == 0) return 1;
    return (v > DIM_LIM) ? DIM_LIM : v;
  endfunction

  // Place the point of the next step from the predictor state; 1 when inside.
  function automatic bit place_point(output longint px, output longint py);
    longint w, h, c, s;
    w = fit_dim(reg_width);
    h = fit_dim(reg_height);
    rotate_phase(walk_phase, c, s);
    px = w * 128 + floor_shift(c * longint'(walk_radius), 15);
    py = h * 128 + floor_shift(s * longint'(walk_radius), 15);
    return (px >= 0 && px < w * 256 && py >= 0 && py < h * 256);
  endfunction

  // Store address that a step taken now would read; 0 when it reads nothing.
  function automatic bit step_addr(output logic [15:0] a);
    longint px, py;
    a = '0;
    if (longint'(walk_radius) >= longint'(reg_maxrad) * 256) return 0;
    if (!place_point(px, py)) return 0;
    a = {py[15:8], px[15:8]};
    return 1;
  endfunction

  // Apply one accepted command to the predictor; returns 1 when a point is due.
  function automatic bit walk_command(input logic [1:0] op, input logic [7:0] row,
                                      input logic [7:0] col, input logic [7:0] val,
                                      output point_t p);
    longint px, py, dr, sum;
    p = '{pv: 0, x: 0, y: 0, done: 0};
    case (op)
      OP_WRITE: begin
        img_mem[{row, col}] = val;
        img_set[{row, col}] = 1;
        return 0;
      end
      OP_RESTART: begin
        walk_radius = 0;
        walk_phase = 0;
        return 0;
      end
      OP_STEP: ;
      default: return 0;
    endcase
    if (longint'(walk_radius) >= longint'(reg_maxrad) * 256) begin
      p.done = 1;
      return 1;
    end
    if (place_point(px, py)) begin
      dr = (longint'(reg_density) * (255 + 20 * longint'(img_mem[{py[15:8], px[15:8]}]))
            + 1275) / 2550;
      p.pv = 1;
      p.x = px[15:0];
      p.y = py[15:0];
    end else begin
      dr = reg_density;
    end
    sum = longint'(walk_radius) + dr;
    walk_radius = (sum > 2097151) ? 21'd2097151 : sum[20:0];
    walk_phase = walk_phase + PHASE_STEP;
    return 1;
  endfunction

  // Clock.
  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  // Drive all inputs known from time zero.
  initial begin
    rst_ni = 0;
    in_if.valid = 0;
    in_if.operation = OP_WRITE;
    in_if.pixel_row = 0;
    in_if.pixel_col = 0;
    in_if.pixel_value = 0;
    out_if.ready = 0;
    cfg_if.valid = 0;
    cfg_if.index = CFG_WIDTH;
    cfg_if.data = 0;
  end

  // Watchdog: generous bound on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 900000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus one long hold-off to back up the block.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_if.ready <= 0;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 12);
        out_if.ready <= 0;
        repeat (gap - 1) @(posedge clk_i);
        @(posedge clk_i);
        out_if.ready <= 1;
      end else begin
        out_if.ready <= 1;
      end
    end
  end

  // Check each result beat against the oldest expectation.
  always @(posedge clk_i) begin
    point_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_points.size() == 0) begin
        $error("result beat with nothing expected");
        err_count++;
      end else begin
        e = expected_points.pop_front();
        if (typed_flags.pop_front()) begin
          // Typed-in rows must agree with the predictor too.
          point_t t;
          t = typed_points.pop_front();
          if (t != e) begin
            $error("table row disagrees: pv %0d/%0d x %0h/%0h y %0h/%0h done %0d/%0d",
                   t.pv, e.pv, t.x, e.x, t.y, e.y, t.done, e.done);
            err_count++;
          end
        end
        if (out_if.point_valid !== e.pv) begin
          $error("point_valid expected %0d actual %0d", e.pv, out_if.point_valid);
          err_count++;
        end
        if (out_if.point_x !== e.x) begin
          $error("point_x expected %0h actual %0h", e.x, out_if.point_x);
          err_count++;
        end
        if (out_if.point_y !== e.y) begin
          $error("point_y expected %0h actual %0h", e.y, out_if.point_y);
          err_count++;
        end
        if (out_if.walk_done !== e.done) begin
          $error("walk_done expected %0d actual %0d", e.done, out_if.walk_done);
          err_count++;
        end
      end
    end
  end

  // Send one command beat; hold until accepted, record the expectation.
  // A step about to read a pixel never written gets that pixel written first.
  task automatic send_cmd(input logic [1:0] op, input logic [7:0] row,
                          input logic [7:0] col, input logic [7:0] val,
                          input bit chk, input point_t res);
    point_t p;
    int gap;
    logic [15:0] a;
    if (op == OP_STEP && step_addr(a) && !img_set[a])
      send_cmd(OP_WRITE, a[15:8], a[7:0], 8'($urandom), 0, '{0, 0, 0, 0});
    if (idle_enable && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 12);
      in_if.valid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1;
    in_if.operation <= op;
    in_if.pixel_row <= row;
    in_if.pixel_col <= col;
    in_if.pixel_value <= val;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sent_count++;
    if (walk_command(op, row, col, val, p)) begin
      expected_points.insert(expected_points.size(), p);
      typed_flags.insert(typed_flags.size(), chk);
      if (chk) typed_points.insert(typed_points.size(), res);
    end
  endtask

  task automatic drop_valid();
    in_if.valid <= 0;
    @(posedge clk_i);
  endtask

  // Wait until all points have come, then let in-flight work settle.
  task automatic drain();
    drop_valid();
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] data);
    cfg_if.valid <= 1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      CFG_WIDTH:   reg_width = data[8:0];
      CFG_HEIGHT:  reg_height = data[8:0];
      CFG_MAXRAD:  reg_maxrad = data;
      default:     reg_density = data[10:0];
    endcase
    cfg_if.valid <= 0;
    @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [8:0] w, input logic [8:0] h,
                          input logic [12:0] mr, input logic [10:0] d);
    write_reg(CFG_WIDTH, 13'(w));
    write_reg(CFG_HEIGHT, 13'(h));
    write_reg(CFG_MAXRAD, mr);
    write_reg(CFG_DENSITY, 13'(d));
  endtask

  initial begin
    row_t dir_rows [13];
    point_t none;
    point_t center;
    int n;
    none = '{pv: 0, x: 0, y: 0, done: 0};
    center = '{pv: 1, x: 16'h8000, y: 16'h8000, done: 0};
    err_count = 0;
    cycle_count = 0;
    sent_count = 0;
    idle_enable = 0;
    hold_off = 0;
    walk_radius = 0;
    walk_phase = 0;
    reg_width = 256;
    reg_height = 256;
    reg_maxrad = 500;
    reg_density = 256;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed table: first step from reset sits at the center.
    dir_rows = '{
      '{OP_STEP, 0, 0, 0, 1, center},
      '{OP_STEP, 0, 0, 0, 0, none},
      '{OP_WRITE, 255, 255, 255, 0, none},
      '{OP_WRITE, 0, 0, 0, 0, none},
      '{OP_WRITE, 128, 128, 255, 0, none},
      '{OP_SPARE, 8'hff, 8'hff, 8'hff, 0, none},  // unused code
      '{OP_RESTART, 0, 0, 0, 0, none},
      '{OP_STEP, 0, 0, 0, 1, center},
      '{OP_STEP, 0, 0, 0, 0, none},
      '{OP_STEP, 0, 0, 0, 0, none},
      '{OP_WRITE, 128, 128, 0, 0, none},
      '{OP_RESTART, 0, 0, 0, 0, none},
      '{OP_STEP, 0, 0, 0, 1, center}
    };
    foreach (dir_rows[i])
      send_cmd(dir_rows[i].op, dir_rows[i].row, dir_rows[i].col, dir_rows[i].val,
               dir_rows[i].chk, dir_rows[i].res);
    drain();

    // Zero max radius: every step reports done.
    set_regs(0, 0, 0, 0);
    send_cmd(OP_RESTART, 0, 0, 0, 0, none);
    for (int i = 0; i < 3; i++) send_cmd(OP_STEP, 0, 0, 0, 1, '{0, 0, 0, 1});
    drain();

    // Random phases over several settings; extremes included.
    idle_enable = 1;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_regs(1, 1, 10, 26);
        1: set_regs(9'h1ff, 9'h1ff, 13'h1fff, 11'h7ff);
        2: set_regs(256, 256, 5000, 1280);
        3: set_regs(0, 300, 40, 0);  // zero density: radius never grows
        4: set_regs(9'($urandom_range(1, 256)), 9'($urandom_range(1, 256)),
                     13'($urandom_range(10, 200)), 11'($urandom_range(26, 1280)));
        default: begin
          set_regs(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                   13'($urandom_range(0, 8191)), 11'($urandom_range(0, 2047)));
          idle_enable = 0;  // last part runs without idling
        end
      endcase
      send_cmd(OP_RESTART, 0, 0, 0, 0, none);
      if (ph == 2) begin
        // Long receiver hold-off while steps keep coming.
        fork
          begin
            hold_off = 1;
            repeat (300) @(posedge clk_i);
            hold_off = 0;
          end
        join_none
      end
      n = sent_count + 120;
      while (sent_count < n) begin
        case ($urandom_range(0, 19))
          0: send_cmd(OP_WRITE, 8'($urandom), 8'($urandom), 8'($urandom), 0, none);
          1: send_cmd(OP_RESTART, 8'($urandom), 8'($urandom), 8'($urandom), 0, none);
          2: send_cmd(OP_SPARE, 8'($urandom), 8'($urandom), 8'($urandom), 0, none);
          default: send_cmd(OP_STEP, 8'($urandom), 8'($urandom), 8'($urandom), 0, none);
        endcase
      end
      drain();
    end

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
